/* rtl/psd_pkg.sv */
// ----------------------------------------------------------------------------
// psd_pkg: shared types and constants of the position stall detector
// Item codes, register map, reset values and sample helpers.
// ----------------------------------------------------------------------------
package psd_pkg;

    localparam int SAMPLE_WIDTH = 32;
    localparam int FIELD_W      = 32;
    localparam int SAMPLE_PAD   = FIELD_W - SAMPLE_WIDTH;
    localparam int LIMIT_W      = 31;
    localparam int TIME_W       = 32;
    localparam int FUNC_W       = 2;
    localparam int IN_DATA_W    = 5 * FIELD_W;
    localparam int IN_USER_W    = FUNC_W + 1;
    localparam int OUT_DATA_W   = 8;
    localparam int APB_ADDR_W   = 5;
    localparam int APB_DATA_W   = 32;
    localparam int REG_IDX_W    = 3;

    // item kinds
    localparam logic [FUNC_W-1:0] FUNC_UPDATE = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_ARM    = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_DISARM = 2'd2;

    // register indexes (byte address = 4 * index)
    localparam logic [REG_IDX_W-1:0] REG_MIN_POS_ERR  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_MAX_SPEED    = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_MIN_EFFORT   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_STALL_TIME   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_GRACE_TIME   = 3'd4;

    localparam logic [LIMIT_W-1:0] RST_MIN_POS_ERR = 31'd6554;
    localparam logic [LIMIT_W-1:0] RST_MAX_SPEED   = 31'd6554;
    localparam logic [LIMIT_W-1:0] RST_MIN_EFFORT  = 31'd65536;
    localparam logic [TIME_W-1:0]  RST_STALL_TIME  = 32'd500;
    localparam logic [TIME_W-1:0]  RST_GRACE_TIME  = 32'd0;

    typedef struct packed {
        logic [LIMIT_W-1:0] min_pos_err;
        logic [LIMIT_W-1:0] max_speed;
        logic [LIMIT_W-1:0] min_effort;
        logic [TIME_W-1:0]  stall_time;
        logic [TIME_W-1:0]  grace_time;
    } t_cfg;

    // one item as held in the input register; speed and effort as magnitudes
    typedef struct packed {
        logic [FUNC_W-1:0]         func;
        logic [TIME_W-1:0]         now_ms;
        logic signed [FIELD_W-1:0] target;
        logic                      feedback_ok;
        logic signed [FIELD_W-1:0] position;
        logic [FIELD_W-1:0]        speed_mag;
        logic [FIELD_W-1:0]        effort_mag;
    } t_item;

    // low SAMPLE_WIDTH bits, sign extended to the field width
    function automatic logic signed [FIELD_W-1:0] sample_sext(input logic [FIELD_W-1:0] x);
        logic signed [FIELD_W-1:0] sh;
        sh = $signed(x << SAMPLE_PAD);
        return sh >>> SAMPLE_PAD;
    endfunction

    function automatic logic [FIELD_W-1:0] sample_mag(input logic signed [FIELD_W-1:0] x);
        return x[FIELD_W-1] ? (~x + 1'b1) : x;
    endfunction

endpackage

/* rtl/psd_regs.sv */
// ----------------------------------------------------------------------------
// psd_regs: configuration register file
// APB-style write and read access to the five detector limits.
// ----------------------------------------------------------------------------
module psd_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [psd_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [psd_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [psd_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready,
    output psd_pkg::t_cfg                   o_cfg
);
    import psd_pkg::*;

    t_cfg                 r_cfg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_pos_err <= RST_MIN_POS_ERR;
            r_cfg.max_speed   <= RST_MAX_SPEED;
            r_cfg.min_effort  <= RST_MIN_EFFORT;
            r_cfg.stall_time  <= RST_STALL_TIME;
            r_cfg.grace_time  <= RST_GRACE_TIME;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_MIN_POS_ERR: r_cfg.min_pos_err <= pwdata[LIMIT_W-1:0];
                REG_MAX_SPEED:   r_cfg.max_speed   <= pwdata[LIMIT_W-1:0];
                REG_MIN_EFFORT:  r_cfg.min_effort  <= pwdata[LIMIT_W-1:0];
                REG_STALL_TIME:  r_cfg.stall_time  <= pwdata[TIME_W-1:0];
                REG_GRACE_TIME:  r_cfg.grace_time  <= pwdata[TIME_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_MIN_POS_ERR: prdata = {1'b0, r_cfg.min_pos_err};
            REG_MAX_SPEED:   prdata = {1'b0, r_cfg.max_speed};
            REG_MIN_EFFORT:  prdata = {1'b0, r_cfg.min_effort};
            REG_STALL_TIME:  prdata = r_cfg.stall_time;
            REG_GRACE_TIME:  prdata = r_cfg.grace_time;
            default:         prdata = '0;
        endcase
    end

endmodule

/* rtl/position_stall_detector.sv */
// ----------------------------------------------------------------------------
// position_stall_detector: joint position stall watchdog
// Arms on a target, times a persistent stall condition and reports it.
// ----------------------------------------------------------------------------
// Pipeline: input register, then one pass of compare logic into the result
//   register, which holds each result until its own output transfer.
// Throughput: one item per cycle while results are taken; the armed/timing
//   state updates as each item advances, so back-to-back items see each
//   other's effects.
// Reset (synchronous, active low): disarmed, timing off, both stages empty,
//   registers at their documented defaults.
module position_stall_detector (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // tdata: now_ms, target_position, measured_position, measured_speed,
    //        drive_effort (32 bits each, from bit 0 up)
    input  logic [psd_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // tuser: func [1:0], feedback_ok [2]
    input  logic [psd_pkg::IN_USER_W-1:0]   s_axis_tuser,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // tdata: stall_detected [0], is_armed [1], is_timing [2], zero fill
    output logic [psd_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [psd_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [psd_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [psd_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);
    import psd_pkg::*;

    t_cfg  cfg;
    t_item in_item;

    logic  r_in_valid, n_in_valid;
    t_item r_in;
    logic  advance;

    logic                      r_armed, n_armed;
    logic                      r_timing, n_timing;
    logic signed [FIELD_W-1:0] r_held_target, n_held_target;
    logic [TIME_W-1:0]         r_arm_time, n_arm_time;
    logic [TIME_W-1:0]         r_stall_start, n_stall_start;
    logic                      n_stall;

    logic                      r_out_valid, n_out_valid;
    logic [2:0]                r_out;

    logic signed [FIELD_W:0]   pos_err;
    logic signed [FIELD_W:0]   err_lim;
    logic                      err_hit, speed_hit, effort_hit, cond;
    logic [TIME_W-1:0]         since_arm, since_start;
    logic                      grace_done;

    psd_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // unpack the transfer; magnitudes of speed and effort formed on entry
    always_comb begin
        in_item.func        = s_axis_tuser[FUNC_W-1:0];
        in_item.feedback_ok = s_axis_tuser[FUNC_W];
        in_item.now_ms      = s_axis_tdata[FIELD_W-1:0];
        in_item.target      = sample_sext(s_axis_tdata[2*FIELD_W-1:FIELD_W]);
        in_item.position    = sample_sext(s_axis_tdata[3*FIELD_W-1:2*FIELD_W]);
        in_item.speed_mag   = sample_mag(sample_sext(s_axis_tdata[4*FIELD_W-1:3*FIELD_W]));
        in_item.effort_mag  = sample_mag(sample_sext(s_axis_tdata[5*FIELD_W-1:4*FIELD_W]));
    end

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign n_in_valid    = s_axis_tready ? s_axis_tvalid : r_in_valid;
    assign n_out_valid   = advance || (r_out_valid && !m_axis_tready);

    // |target - position| >= limit, checked against both signs of the limit
    assign pos_err     = {r_held_target[FIELD_W-1], r_held_target}
                       - {r_in.position[FIELD_W-1], r_in.position};
    assign err_lim     = $signed({2'b00, cfg.min_pos_err});
    assign err_hit     = (pos_err >= err_lim) || (pos_err <= -err_lim);
    assign speed_hit   = r_in.speed_mag <= {1'b0, cfg.max_speed};
    assign effort_hit  = r_in.effort_mag >= {1'b0, cfg.min_effort};
    assign cond        = err_hit && speed_hit && effort_hit;
    assign since_arm   = r_in.now_ms - r_arm_time;
    assign since_start = r_in.now_ms - r_stall_start;
    assign grace_done  = since_arm >= cfg.grace_time;

    always_comb begin
        n_armed       = r_armed;
        n_timing      = r_timing;
        n_held_target = r_held_target;
        n_arm_time    = r_arm_time;
        n_stall_start = r_stall_start;
        n_stall       = 1'b0;
        if (advance) begin
            priority if (r_in.func == FUNC_ARM) begin
                if (!(r_armed && r_held_target == r_in.target)) begin
                    n_held_target = r_in.target;
                    n_arm_time    = r_in.now_ms;
                    n_stall_start = '0;
                    n_armed       = 1'b1;
                    n_timing      = 1'b0;
                end
            end else if (r_in.func == FUNC_DISARM) begin
                n_armed       = 1'b0;
                n_timing      = 1'b0;
                n_stall_start = '0;
            end else if (r_in.func == FUNC_UPDATE && r_armed) begin
                if (!r_in.feedback_ok || !grace_done || !cond) begin
                    n_timing = 1'b0;
                end else if (!r_timing) begin
                    n_timing      = 1'b1;
                    n_stall_start = r_in.now_ms;
                end else if (since_start >= cfg.stall_time) begin
                    n_armed       = 1'b0;
                    n_timing      = 1'b0;
                    n_stall_start = '0;
                    n_stall       = 1'b1;
                end
            end else begin
                // unused code or update while disarmed: state holds
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_armed       <= 1'b0;
            r_timing      <= 1'b0;
            r_held_target <= '0;
            r_arm_time    <= '0;
            r_stall_start <= '0;
        end else begin
            r_in_valid    <= n_in_valid;
            r_out_valid   <= n_out_valid;
            r_armed       <= n_armed;
            r_timing      <= n_timing;
            r_held_target <= n_held_target;
            r_arm_time    <= n_arm_time;
            r_stall_start <= n_stall_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready) begin
            r_in <= in_item;
        end
        if (advance) begin
            r_out <= {n_timing, n_armed, n_stall};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_DATA_W-3){1'b0}}, r_out};

endmodule

/* rtl/psd_checker.sv */
// ----------------------------------------------------------------------------
// psd_checker: port-level checks of the position stall detector
// Watches result flags, output stalls and the config port over time.
// ----------------------------------------------------------------------------
module psd_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic [psd_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic                            pready
);
    import psd_pkg::*;

    // a confirmed stall always leaves the block disarmed and not timing
    a_stall_disarms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[0] |-> !m_axis_tdata[1] && !m_axis_tdata[2])
        else $error("stall reported while still armed or timing");

    // timing only ever runs while armed
    a_timing_armed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[2] |-> m_axis_tdata[1])
        else $error("timing flag set without armed flag");

    // hold a pending result until its transfer
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("pending result dropped or changed");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n) pready)
        else $error("config port not ready");

endmodule

bind position_stall_detector psd_checker u_psd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .pready        (pready)
);

/* dv/position_stall_detector_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// position_stall_detector_tb: self-checking bench for the stall detector
// Streams arm, disarm and update items through the block, predicts the
// armed, timing and stall flags of every item in a local model, and checks
// each result transfer against the oldest prediction. Directed cases cover
// the thresholds, time wrap and register masking; random phases then run
// under several register settings with idle gaps and output back-pressure.
// ----------------------------------------------------------------------------
module position_stall_detector_tb;
    import psd_pkg::*;

    localparam int CLK_PERIOD       = 8;
    localparam int RESET_CYCLES     = 9;
    localparam int IDLE_LIMIT       = 5000;
    localparam int SINK_HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES    = 8;
    localparam int MAX_REPORTS      = 40;

    localparam logic [FUNC_W-1:0]    FUNC_UNUSED  = 2'd3;
    localparam logic [REG_IDX_W-1:0] REG_UNMAPPED = 3'd5;

    typedef struct {
        logic [FUNC_W-1:0]  func;
        logic [TIME_W-1:0]  now;
        logic signed [31:0] target;
        logic               fb_ok;
        logic signed [31:0] pos;
        logic signed [31:0] speed;
        logic signed [31:0] effort;
    } sample_item_t;

    typedef struct {
        logic stall;
        logic armed;
        logic timing;
    } detector_flags_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    // tdata: now_ms, target_position, measured_position, measured_speed,
    //        drive_effort (32 bits each, from bit 0 up)
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    // tuser: func [1:0], feedback_ok [2]
    logic [IN_USER_W-1:0]  s_axis_tuser = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // tdata: stall_detected [0], is_armed [1], is_timing [2], zero fill
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // detector model state and its copy of the registers
    t_cfg              det_cfg;
    longint            det_target = 0;
    logic [TIME_W-1:0] det_arm_time = '0;
    logic [TIME_W-1:0] det_stall_start = '0;
    logic              det_armed = 1'b0;
    logic              det_timing = 1'b0;

    detector_flags_t   expected_flags_q[$];
    int                items_sent = 0;
    int                results_seen = 0;
    int                error_count = 0;
    int                idle_cycles = 0;

    // stimulus knobs
    logic [TIME_W-1:0] gen_now = '0;
    logic [31:0]       gen_target = '0;
    bit                src_gaps_on = 1'b1;
    bit                sink_gaps_on = 1'b1;
    bit                sink_hold_req = 1'b0;

    position_stall_detector dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    task automatic flag_error(input string msg);
        if (error_count < MAX_REPORTS) begin
            $display("ERROR @%0t: %s", $time, msg);
        end
        error_count++;
    endtask

    // low SAMPLE_WIDTH bits of a field, sign extended
    function automatic longint as_sample(input logic [31:0] x);
        longint v;
        v = longint'(x) << (64 - SAMPLE_WIDTH);
        return v >>> (64 - SAMPLE_WIDTH);
    endfunction

    function automatic longint magnitude(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic detector_flags_t detector_step(input sample_item_t it);
        detector_flags_t   r;
        longint            tgt;
        longint            err_mag;
        longint            spd_mag;
        longint            eff_mag;
        logic [TIME_W-1:0] since_arm;
        r.stall = 1'b0;
        tgt = as_sample(it.target);
        case (it.func)
            FUNC_ARM: begin
                // a repeat arm on the same target keeps the original arm time
                if (!(det_armed && det_target == tgt)) begin
                    det_target      = tgt;
                    det_arm_time    = it.now;
                    det_stall_start = '0;
                    det_armed       = 1'b1;
                    det_timing      = 1'b0;
                end
            end
            FUNC_DISARM: begin
                det_armed       = 1'b0;
                det_timing      = 1'b0;
                det_stall_start = '0;
            end
            FUNC_UPDATE: begin
                if (det_armed) begin
                    since_arm = it.now - det_arm_time;
                    if (!it.fb_ok || since_arm < det_cfg.grace_time) begin
                        det_timing = 1'b0;
                    end else begin
                        err_mag = magnitude(det_target - as_sample(it.pos));
                        spd_mag = magnitude(as_sample(it.speed));
                        eff_mag = magnitude(as_sample(it.effort));
                        if (err_mag < longint'(det_cfg.min_pos_err)
                                || spd_mag > longint'(det_cfg.max_speed)
                                || eff_mag < longint'(det_cfg.min_effort)) begin
                            det_timing = 1'b0;
                        end else if (!det_timing) begin
                            det_timing      = 1'b1;
                            det_stall_start = it.now;
                        end else if (it.now - det_stall_start >= det_cfg.stall_time) begin
                            det_armed       = 1'b0;
                            det_timing      = 1'b0;
                            det_stall_start = '0;
                            r.stall         = 1'b1;
                        end
                    end
                end
            end
            default: ;
        endcase
        r.armed  = det_armed;
        r.timing = det_timing;
        return r;
    endfunction

    // predict on every input transfer, check on every output transfer
    always @(posedge i_clk) begin : scoreboard
        sample_item_t    seen;
        detector_flags_t want;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                seen.func   = s_axis_tuser[1:0];
                seen.fb_ok  = s_axis_tuser[2];
                seen.now    = s_axis_tdata[31:0];
                seen.target = s_axis_tdata[63:32];
                seen.pos    = s_axis_tdata[95:64];
                seen.speed  = s_axis_tdata[127:96];
                seen.effort = s_axis_tdata[159:128];
                expected_flags_q.push_back(detector_step(seen));
            end
            if (m_axis_tvalid && m_axis_tready) begin
                results_seen++;
                if (expected_flags_q.size() == 0) begin
                    flag_error($sformatf("result %0d with no item pending", results_seen));
                end else begin
                    want = expected_flags_q.pop_front();
                    if (m_axis_tdata[0] !== want.stall) begin
                        flag_error($sformatf("result %0d: stall_detected %b, expected %b",
                                             results_seen, m_axis_tdata[0], want.stall));
                    end
                    if (m_axis_tdata[1] !== want.armed) begin
                        flag_error($sformatf("result %0d: is_armed %b, expected %b",
                                             results_seen, m_axis_tdata[1], want.armed));
                    end
                    if (m_axis_tdata[2] !== want.timing) begin
                        flag_error($sformatf("result %0d: is_timing %b, expected %b",
                                             results_seen, m_axis_tdata[2], want.timing));
                    end
                    if (m_axis_tdata[7:3] !== '0) begin
                        flag_error($sformatf("result %0d: fill bits %b, expected zero",
                                             results_seen, m_axis_tdata[7:3]));
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    function automatic int gap_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 80) return $urandom_range(1, 3);
        if (pick < 96) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // result side: random stalls, plus one long hold on request
    initial begin : result_sink
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (sink_hold_req) begin
                hold_left     = SINK_HOLD_CYCLES;
                sink_hold_req = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (sink_gaps_on && $urandom_range(0, 99) < 25) begin
                hold_left = gap_len() - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // start at a rising edge; return at the edge of the transfer, valid held
    task automatic send_item(input sample_item_t it);
        int gap;
        gap = (src_gaps_on && $urandom_range(0, 99) < 30) ? gap_len() : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tdata  <= {it.effort, it.speed, it.pos, it.target, it.now};
        s_axis_tuser  <= {it.fb_ok, it.func};
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        items_sent++;
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (results_seen < items_sent) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // idle bus phase between transfers
        @(posedge i_clk);
        case (idx)
            REG_MIN_POS_ERR: det_cfg.min_pos_err = value[LIMIT_W-1:0];
            REG_MAX_SPEED:   det_cfg.max_speed   = value[LIMIT_W-1:0];
            REG_MIN_EFFORT:  det_cfg.min_effort  = value[LIMIT_W-1:0];
            REG_STALL_TIME:  det_cfg.stall_time  = value;
            REG_GRACE_TIME:  det_cfg.grace_time  = value;
            default: ;
        endcase
    endtask

    function automatic sample_item_t make_item(input logic [FUNC_W-1:0] func,
                                               input logic [31:0] now, input logic [31:0] target,
                                               input logic fb_ok, input logic [31:0] pos,
                                               input logic [31:0] speed, input logic [31:0] effort);
        sample_item_t it;
        it.func   = func;
        it.now    = now;
        it.target = target;
        it.fb_ok  = fb_ok;
        it.pos    = pos;
        it.speed  = speed;
        it.effort = effort;
        return it;
    endfunction

    // magnitude around a threshold, mostly on the side that keeps the stall test true
    function automatic longint near_limit(input longint lim, input bit want_ge);
        int     pick;
        longint m;
        pick = $urandom_range(0, 99);
        if (pick < 3) begin
            m = lim;
        end else if (pick < 6) begin
            m = want_ge ? lim - 1 : lim + 1;
        end else if (pick < 9) begin
            m = longint'($urandom);
        end else if (pick < 12) begin
            m = want_ge ? lim - longint'($urandom_range(2, 5000))
                        : lim + longint'($urandom_range(2, 5000));
        end else begin
            m = want_ge ? lim + longint'($urandom_range(0, 5000))
                        : lim - longint'($urandom_range(0, 5000));
        end
        return (m < 0) ? 0 : m;
    endfunction

    function automatic sample_item_t random_item();
        sample_item_t it;
        int           pick;
        longint       err_mag;
        longint       spd_mag;
        longint       eff_mag;
        pick = $urandom_range(0, 99);
        if (pick < 5) begin
            gen_now = $urandom;
        end else if (pick < 15) begin
            gen_now += $urandom_range(0, 300);
        end else if (pick < 90) begin
            gen_now += $urandom_range(0, 8);
        end
        it.now    = gen_now;
        it.fb_ok  = ($urandom_range(0, 99) < 96);
        // fields the item kind does not use carry noise
        it.target = $urandom;
        it.pos    = $urandom;
        it.speed  = $urandom;
        it.effort = $urandom;
        pick = $urandom_range(0, 99);
        if (pick < 7) begin
            it.func = FUNC_ARM;
            case ($urandom_range(0, 5))
                0, 1: ;
                2: gen_target = $urandom;
                3: gen_target = 32'h7FFF_FFFF;
                4: gen_target = 32'h8000_0000;
                default: gen_target = $urandom_range(0, 65535) - 32768;
            endcase
            it.target = gen_target;
        end else if (pick < 10) begin
            it.func = FUNC_DISARM;
        end else if (pick < 11) begin
            it.func = FUNC_UNUSED;
        end else begin
            it.func = FUNC_UPDATE;
            err_mag = near_limit(det_cfg.min_pos_err, 1'b1);
            spd_mag = near_limit(det_cfg.max_speed, 1'b0);
            eff_mag = near_limit(det_cfg.min_effort, 1'b1);
            if ($urandom_range(0, 99) >= 4) begin
                it.pos = $urandom_range(0, 1) ? 32'(longint'(gen_target) - err_mag)
                                              : 32'(longint'(gen_target) + err_mag);
            end
            it.speed  = $urandom_range(0, 1) ? 32'(-spd_mag) : 32'(spd_mag);
            it.effort = $urandom_range(0, 1) ? 32'(-eff_mag) : 32'(eff_mag);
        end
        return it;
    endfunction

    task automatic test_arm_and_disarm();
        send_item(make_item(FUNC_UPDATE, 10, 0, 1'b1, 0, 0, 32'h0001_0000));
        send_item(make_item(FUNC_UNUSED, 20, 32'h1234_5678, 1'b1, '1, '1, '1));
        send_item(make_item(FUNC_ARM, 100, 32'h0001_0000, 1'b0, 0, 0, 0));
        send_item(make_item(FUNC_ARM, 150, 32'h0001_0000, 1'b0, 0, 0, 0));
        send_item(make_item(FUNC_DISARM, 160, 0, 1'b0, 0, 0, 0));
        send_item(make_item(FUNC_ARM, 200, 32'h0001_0000, 1'b0, 0, 0, 0));
        send_item(make_item(FUNC_ARM, 210, 32'hFFFF_0000, 1'b0, 0, 0, 0));
    endtask

    task automatic test_stall_timing();
        // target -1.0: error, speed and effort each exactly on their limit
        send_item(make_item(FUNC_UPDATE, 300, 0, 1'b0, -58982, -6554, -65536));
        send_item(make_item(FUNC_UPDATE, 300, 0, 1'b1, -58982, -6554, -65536));
        send_item(make_item(FUNC_UPDATE, 799, 0, 1'b1, -58982, -6554, -65536));
        send_item(make_item(FUNC_UPDATE, 800, 0, 1'b1, -58982, -6554, -65536));
        // largest error, and a stall window that crosses the tick wrap
        send_item(make_item(FUNC_ARM, 32'hFFFF_FF00, 32'h7FFF_FFFF, 1'b0, 0, 0, 0));
        send_item(make_item(FUNC_UPDATE, 32'hFFFF_FFF0, 0, 1'b1, 32'h8000_0000, 0,
                            32'h7FFF_FFFF));
        send_item(make_item(FUNC_UPDATE, 32'h0000_01E3, 0, 1'b1, 32'h8000_0000, 0,
                            32'h7FFF_FFFF));
        send_item(make_item(FUNC_UPDATE, 32'h0000_01E4, 0, 1'b1, 32'h8000_0000, 0,
                            32'h7FFF_FFFF));
        // each test failing on its own
        send_item(make_item(FUNC_ARM, 0, 32'h7FFF_FFFF, 1'b0, 0, 0, 0));
        send_item(make_item(FUNC_UPDATE, 5, 0, 1'b1, 32'h8000_0000, 32'h8000_0000,
                            32'h8000_0000));
        send_item(make_item(FUNC_UPDATE, 6, 0, 1'b1, 0, 6555, 65536));
        send_item(make_item(FUNC_UPDATE, 7, 0, 1'b1, 0, 6554, 65535));
        send_item(make_item(FUNC_UPDATE, 8, 0, 1'b1, 32'h7FFF_FFFF, 0, 65536));
        send_item(make_item(FUNC_UPDATE, 9, 0, 1'b1, 32'h7FFF_E667, 0, 65536));
    endtask

    task automatic test_register_extremes();
        wait_idle();
        // bit 31 is dropped by the 31-bit limit registers
        reg_write(REG_MIN_POS_ERR, 32'h8000_0000);
        reg_write(REG_MAX_SPEED, 32'hFFFF_FFFF);
        reg_write(REG_MIN_EFFORT, 32'h8000_0000);
        reg_write(REG_STALL_TIME, 32'h0000_0000);
        reg_write(REG_GRACE_TIME, 32'hFFFF_FFFF);
        reg_write(REG_UNMAPPED, 32'hFFFF_FFFF);
        send_item(make_item(FUNC_ARM, 1000, 32'h0000_4000, 1'b0, 0, 0, 0));
        send_item(make_item(FUNC_UPDATE, 1001, 0, 1'b1, 32'h0000_4000, 32'h8000_0001, 0));
        wait_idle();
        reg_write(REG_GRACE_TIME, 32'h0000_0000);
        send_item(make_item(FUNC_UPDATE, 1002, 0, 1'b1, 32'h0000_4000, 32'h8000_0001, 0));
        send_item(make_item(FUNC_UPDATE, 1002, 0, 1'b1, 32'h0000_4000, 32'h8000_0001, 0));
    endtask

    task automatic run_random_phase(input logic [31:0] err_lim, input logic [31:0] spd_lim,
                                    input logic [31:0] eff_lim, input logic [31:0] stall_ms,
                                    input logic [31:0] grace_ms, input int n_items);
        wait_idle();
        reg_write(REG_MIN_POS_ERR, err_lim);
        reg_write(REG_MAX_SPEED, spd_lim);
        reg_write(REG_MIN_EFFORT, eff_lim);
        reg_write(REG_STALL_TIME, stall_ms);
        reg_write(REG_GRACE_TIME, grace_ms);
        repeat (n_items) send_item(random_item());
    endtask

    task automatic test_random_phases();
        src_gaps_on  = 1'b1;
        sink_gaps_on = 1'b1;
        run_random_phase($urandom_range(1, 20000), $urandom_range(0, 20000),
                         $urandom_range(0, 100000), $urandom_range(1, 40),
                         $urandom_range(0, 10), 250);
        src_gaps_on  = 1'b0;
        sink_gaps_on = 1'b0;
        run_random_phase(32'h7FFF_FFFF, 0, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 60);
        src_gaps_on  = 1'b1;
        run_random_phase(1, 32'h7FFF_FFFF, 0, 1, 0, 250);
        src_gaps_on  = 1'b0;
        sink_gaps_on = 1'b1;
        run_random_phase($urandom, $urandom, $urandom, $urandom, $urandom, 100);
        src_gaps_on  = 1'b1;
        run_random_phase($urandom_range(1, 2000), $urandom_range(0, 2000),
                         $urandom_range(0, 2000), $urandom_range(1, 20),
                         $urandom_range(0, 30), 250);
        run_random_phase($urandom_range(1, 20000), $urandom_range(0, 20000),
                         $urandom_range(0, 100000), $urandom_range(1, 40), 0, 250);
    endtask

    task automatic test_output_backpressure();
        wait_idle();
        reg_write(REG_STALL_TIME, 4);
        reg_write(REG_GRACE_TIME, 0);
        // keep offering while results are held off, so the input stalls
        src_gaps_on   = 1'b0;
        sink_hold_req = 1'b1;
        repeat (60) send_item(random_item());
        src_gaps_on   = 1'b1;
    endtask

    initial begin : test_sequence
        det_cfg.min_pos_err = RST_MIN_POS_ERR;
        det_cfg.max_speed   = RST_MAX_SPEED;
        det_cfg.min_effort  = RST_MIN_EFFORT;
        det_cfg.stall_time  = RST_STALL_TIME;
        det_cfg.grace_time  = RST_GRACE_TIME;
        i_rst_n <= 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_arm_and_disarm();
        test_stall_timing();
        test_register_extremes();
        test_random_phases();
        test_output_backpressure();
        wait_idle();
        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
